### hdl/spectral_bin_event_tracker_macros.svh
// Assertion macros for the spectral bin event tracker.
// No dependencies; included by the files that assert.
`ifndef SPECTRAL_BIN_EVENT_TRACKER_MACROS_SVH
`define SPECTRAL_BIN_EVENT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SBET_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbet assertion failed");
// next-cycle implication
`define SBET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbet assertion failed");
`else
`define SBET_ASSERT(label, clk, rst_n, ante, cons)
`define SBET_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/sbet_pkg.sv
// Shared types and constants of the spectral bin event tracker.
// No dependencies.
package sbet_pkg;
	localparam int NUM_BINS_DEF = 512;
	localparam int BIN_W = 9;
	localparam int MAG_W = 24;
	localparam int TIME_W = 32;
	localparam int DUR_W = 16;
	localparam int GAP_W = 18;
	localparam int CHG_W = 10;
	localparam int ACT_W = 2;
	localparam int REG_W = 16;

	localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_GAP_LIMIT = 1'b1;

	localparam logic [GAP_W-1:0] GAP_MAX = 18'd131071;
	localparam logic [GAP_W-1:0] GAP_NONE = '1;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;
	localparam logic [CHG_W-1:0] CHG_MAX = '1;

	localparam logic [DUR_W-1:0] MIN_LEN_RST = 16'd3;
	localparam logic [DUR_W-1:0] GAP_LIMIT_RST = 16'd2;

	// one bin's record in the state memory
	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [TIME_W-1:0] start;
		logic [GAP_W-1:0]  gap;
		logic [DUR_W-1:0]  dur;
		logic [MAG_W-1:0]  amp;
	} rec_t;

	localparam rec_t REC_CLEAR = '{act: ACT_NONE, start: '0, gap: GAP_NONE,
		dur: '0, amp: '0};

	// classified word in the queue
	typedef struct packed {
		logic [BIN_W-1:0]  bin;
		logic              is_peak;
		logic [MAG_W-1:0]  magnitude;
		logic [TIME_W-1:0] frame_time;
		logic              frame_end;
		logic              in_range;
	} item_t;

	typedef struct packed {
		logic [DUR_W-1:0] min_len;
		logic [DUR_W-1:0] gap_limit;
	} cfg_t;

	// back part status towards the front
	typedef struct packed {
		logic clr_done;
	} stat_t;
endpackage

### hdl/sbet_item_if.sv
// Input channel of the tracker: one bin of one frame per word.
// No dependencies.
interface sbet_item_if;
	logic        valid;
	logic        ready;
	logic [8:0]  bin;
	logic        is_peak;
	logic [23:0] magnitude;
	logic [31:0] frame_time;
	logic        frame_end;

	modport source(output valid, bin, is_peak, magnitude, frame_time, frame_end,
		input ready);
	modport sink(input valid, bin, is_peak, magnitude, frame_time, frame_end,
		output ready);
endinterface

### hdl/sbet_result_if.sv
// Result channel of the tracker: one word per input word.
// No dependencies.
interface sbet_result_if;
	logic        valid;
	logic        ready;
	logic [8:0]  bin_out;
	logic [1:0]  action;
	logic [31:0] start_time;
	logic [15:0] duration_out;
	logic [23:0] amplitude_out;
	logic [9:0]  change_count;
	logic        frame_last;

	modport source(output valid, bin_out, action, start_time, duration_out,
		amplitude_out, change_count, frame_last, input ready);
	modport sink(input valid, bin_out, action, start_time, duration_out,
		amplitude_out, change_count, frame_last, output ready);
endinterface

### hdl/sbet_front.sv
// Front part: accepts input words, checks the bin range, queues two words.
// Depends on sbet_pkg and sbet_item_if.
module sbet_front #(
	parameter int NUM_BINS = sbet_pkg::NUM_BINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	sbet_item_if.sink           item,
	input  sbet_pkg::stat_t     stat,
	input  logic                pop,
	output logic                head_valid,
	output sbet_pkg::item_t     head
);
	import sbet_pkg::*;

	item_t      fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      wr_item;

	// no words taken while the state memory is cleared
	assign item.ready = (cnt_q != 2'd2) && stat.clr_done;
	assign push = item.valid && item.ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head = fifo_q[rp_q];

	// classify
	always_comb begin
		wr_item.bin = item.bin;
		wr_item.is_peak = item.is_peak;
		wr_item.magnitude = item.magnitude;
		wr_item.frame_time = item.frame_time;
		wr_item.frame_end = item.frame_end;
		wr_item.in_range = (32'(item.bin) < 32'(NUM_BINS));
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= wr_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

### hdl/sbet_div.sv
// Restoring divider for the running mean: one quotient bit per cycle.
// Depends on sbet_pkg.
module sbet_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sbet_pkg::MAG_W-1:0]   dividend,
	input  logic [sbet_pkg::DUR_W-1:0]   divisor,
	output logic                         done,
	output logic [sbet_pkg::MAG_W-1:0]   quotient
);
	import sbet_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] quo_q;
	logic [DUR_W-1:0] dsr_q;
	logic [DUR_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DUR_W:0]   trial;
	logic             fits;

	// one restoring step
	assign trial = {rem_q[DUR_W-1:0], quo_q[MAG_W-1]};
	assign fits = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

### hdl/sbet_back.sv
// Back part: state memory, event update, divider control, result register.
// Depends on sbet_pkg, sbet_div and sbet_result_if.
module sbet_back #(
	parameter int NUM_BINS = sbet_pkg::NUM_BINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sbet_pkg::cfg_t      cfg,
	input  logic                head_valid,
	input  sbet_pkg::item_t     head,
	output logic                pop,
	output sbet_pkg::stat_t     stat,
	sbet_result_if.source       result
);
	import sbet_pkg::*;

	localparam int AW = $clog2(NUM_BINS);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} bst_t;

	bst_t state_q;
	rec_t mem [NUM_BINS];
	rec_t rd_q;
	logic [AW-1:0] clr_q, addr_q;
	item_t cur_q;
	rec_t  new_q;
	logic  neg_q;
	logic [MAG_W-1:0] mag_diff;
	logic [CHG_W-1:0] chg_q, chg_new_q;

	logic mem_we;
	logic [AW-1:0] mem_wa;
	rec_t mem_wd;
	logic out_free, out_vld_q;
	logic div_start, div_done;
	logic [MAG_W-1:0] quo;

	// update of one record
	rec_t rec, nrec;
	logic [GAP_W-1:0] g;
	logic [GAP_W-2:0] add;
	logic [GAP_W-1:0] sum;
	logic [CHG_W-1:0] chg_nx;

	always_comb begin
		rec = rd_q;
		if (rec.act == ACT_FINISH) begin
			rec = REC_CLEAR;
		end
		nrec = rec;
		nrec.act = ACT_NONE;
		g = rec.gap;
		add = '0;
		sum = '0;
		if (cur_q.is_peak) begin
			if ($signed(g) < $signed(GAP_MAX)) g = g + 1'b1;
			add = ($signed(g) < 18'sd1) ? 17'd1 : g[GAP_W-2:0];
			sum = {2'b00, rec.dur} + {1'b0, add};
			if (rec.dur < cfg.min_len && sum >= {2'b00, cfg.min_len}) begin
				nrec.act = ACT_START;
				nrec.start = cur_q.frame_time - 32'(rec.dur) - 32'(add) + 32'd1;
			end
			nrec.dur = (sum > {2'b00, DUR_MAX}) ? DUR_MAX : sum[DUR_W-1:0];
			nrec.gap = '0;
		end else if (!rec.gap[GAP_W-1]) begin
			if (rec.gap < GAP_MAX) g = rec.gap + 1'b1;
			nrec.gap = g;
			if (g > {2'b00, cfg.gap_limit}) begin
				if (rec.dur >= cfg.min_len) begin
					nrec.act = ACT_FINISH;
				end else begin
					nrec = REC_CLEAR;
				end
			end
		end
		chg_nx = chg_q;
		if (nrec.act != ACT_NONE && chg_q != CHG_MAX) chg_nx = chg_q + 1'b1;
	end

	assign out_free = !out_vld_q || result.ready;
	assign pop = (state_q == ST_IDLE) && head_valid;
	assign div_start = (state_q == ST_READ) && cur_q.is_peak;
	assign stat.clr_done = (state_q != ST_CLEAR);

	// memory write port: clearing pass or record write-back
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = new_q;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = REC_CLEAR;
		end else if (state_q == ST_OUT && out_free && cur_q.in_range) begin
			mem_we = 1'b1;
		end
	end

	// state memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[AW'(head.bin)];
	end

	sbet_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_diff),
		.divisor  (nrec.dur),
		.done     (div_done),
		.quotient (quo)
	);

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					cur_q <= head;
					addr_q <= AW'(head.bin);
					new_q <= '0;
					chg_new_q <= chg_q;
				end
			end
			ST_READ: begin
				new_q <= nrec;
				chg_new_q <= chg_nx;
			end
			ST_DIV: begin
				if (div_done) begin
					new_q.amp <= neg_q ? (new_q.amp - quo) : (new_q.amp + quo);
				end
			end
			default: begin
			end
		endcase
	end

	// magnitude difference for the mean, latched as the record is read
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			neg_q <= 1'b0;
		end
		if (state_q == ST_READ) begin
			neg_q <= (cur_q.magnitude < rec.amp);
		end
	end
	always_comb begin
		mag_diff = (cur_q.magnitude >= rec.amp) ? (cur_q.magnitude - rec.amp)
			: (rec.amp - cur_q.magnitude);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			chg_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_BINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (head_valid) state_q <= head.in_range ? ST_READ : ST_OUT;
				end
				ST_READ: begin
					state_q <= cur_q.is_peak ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						chg_q <= cur_q.frame_end ? '0 : chg_new_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	logic [BIN_W-1:0]  bin_q;
	logic [ACT_W-1:0]  act_q;
	logic [TIME_W-1:0] start_q;
	logic [DUR_W-1:0]  dur_q;
	logic [MAG_W-1:0]  amp_q;
	logic [CHG_W-1:0]  cnt_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			bin_q <= cur_q.bin;
			act_q <= new_q.act;
			start_q <= new_q.start;
			dur_q <= new_q.dur;
			amp_q <= new_q.amp;
			cnt_q <= chg_new_q;
			last_q <= cur_q.frame_end;
		end
	end

	assign result.valid = out_vld_q;
	assign result.bin_out = bin_q;
	assign result.action = act_q;
	assign result.start_time = start_q;
	assign result.duration_out = dur_q;
	assign result.amplitude_out = amp_q;
	assign result.change_count = cnt_q;
	assign result.frame_last = last_q;
endmodule

### hdl/spectral_bin_event_tracker.sv
// Top level of the spectral bin event tracker: configuration registers, front and back
// parts. Depends on sbet_pkg, sbet_front, sbet_back, the interfaces and the macros header.
//
// One result word per input word. After reset the bin state memory is cleared
// one entry a cycle while no input word is taken. A peak word is taken, its
// record is read, the 24-step running-mean divider runs and the result is
// posted. A peakless word skips the divider, and an out-of-range word also
// skips the record read. The back part takes no new word until the last is posted.
// A result held at the output stalls the back part; a two-word queue lets input
// words be taken meanwhile.
`include "spectral_bin_event_tracker_macros.svh"
module spectral_bin_event_tracker #(
	parameter int NUM_BINS = sbet_pkg::NUM_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sbet_item_if.sink                   item,
	sbet_result_if.source               result,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [sbet_pkg::REG_W-1:0]  wr_data
);
	import sbet_pkg::*;

	cfg_t  cfg_q;
	stat_t stat;
	logic  pop, head_valid;
	item_t head;
	logic  start_word, last_taken;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_len <= MIN_LEN_RST;
			cfg_q.gap_limit <= GAP_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MIN_LEN:   cfg_q.min_len <= wr_data;
				REG_GAP_LIMIT: cfg_q.gap_limit <= wr_data;
				default: begin
				end
			endcase
		end
	end

	sbet_front #(.NUM_BINS(NUM_BINS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.stat       (stat),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sbet_back #(.NUM_BINS(NUM_BINS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.stat       (stat),
		.result     (result)
	);

	// checks
	assign start_word = result.valid && (result.action == ACT_START);
	assign last_taken = result.valid && result.ready && result.frame_last;

	`SBET_ASSERT(a_no_take_in_clear, clk, arst_n, !stat.clr_done, !item.ready)
	`SBET_ASSERT(a_start_has_dur, clk, arst_n, start_word, result.duration_out != 16'd0)
	`SBET_ASSERT_NEXT(a_last_clears_count, clk, arst_n, last_taken, !result.valid || result.change_count <= 10'd1)
endmodule

### verif/spectral_bin_event_tracker_tb.sv
// Testbench of the spectral bin event tracker: directed and random frames of bin words.
// Depends on sbet_pkg, sbet_item_if, sbet_result_if and the tracker top level.
`timescale 1ns / 100ps

module spectral_bin_event_tracker_tb;
	import sbet_pkg::*;

	localparam int NBINS = NUM_BINS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [8:0]  bin_out;
		logic [1:0]  action;
		logic [31:0] start_time;
		logic [15:0] duration_out;
		logic [23:0] amplitude_out;
		logic [9:0]  change_count;
		logic        frame_last;
	} track_word_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic [REG_W-1:0] wr_data;

	sbet_item_if   item();
	sbet_result_if result();

	spectral_bin_event_tracker DUT (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// tracker image: per-bin records, frame change count, registers
	logic [1:0]  trk_act [NBINS];
	logic [31:0] trk_start [NBINS];
	int          trk_gap [NBINS];
	logic [31:0] trk_dur [NBINS];
	logic [31:0] trk_amp [NBINS];
	logic [9:0]  trk_changes;
	logic [15:0] trk_min_len;
	logic [15:0] trk_prox;

	track_word_t pending_tracks[$];
	int fail_count;
	int words_sent;
	int words_checked;
	int starts_seen;
	int finishes_seen;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int hold_left;

	always #10 clk = ~clk;

	function automatic void clear_track(int b);
		trk_start[b] = '0;
		trk_gap[b] = -1;
		trk_dur[b] = '0;
		trk_amp[b] = '0;
	endfunction

	function automatic void bump_changes();
		if (trk_changes != CHG_MAX)
			trk_changes++;
	endfunction

	// advance the tracker image by one bin word and form its result
	function automatic track_word_t track_bin(logic [8:0] b, logic pk, logic [23:0] mag,
			logic [31:0] t, logic fend);
		track_word_t r;
		logic [1:0] act;
		int g;
		logic [31:0] add;
		logic [31:0] dur;
		logic [31:0] amp;
		act = ACT_NONE;
		if (trk_act[b] == ACT_FINISH)
			clear_track(b);
		if (pk) begin
			g = trk_gap[b];
			if (g < int'(GAP_MAX))
				g++;
			add = (g < 1) ? 32'd1 : 32'(g);
			dur = trk_dur[b];
			if (dur < trk_min_len && (dur + add) >= trk_min_len) begin
				act = ACT_START;
				trk_start[b] = t - dur - add + 32'd1;
				bump_changes();
			end
			dur = dur + add;
			if (dur > 32'hFFFF)
				dur = 32'hFFFF;
			trk_dur[b] = dur;
			amp = trk_amp[b];
			if (mag >= amp)
				amp = amp + (32'(mag) - amp) / dur;
			else
				amp = amp - (amp - 32'(mag)) / dur;
			trk_amp[b] = amp & 32'hFFFFFF;
			trk_gap[b] = 0;
		end else if (trk_gap[b] >= 0) begin
			if (trk_gap[b] < int'(GAP_MAX))
				trk_gap[b]++;
			if (trk_gap[b] > int'(trk_prox)) begin
				if (trk_dur[b] >= trk_min_len) begin
					act = ACT_FINISH;
					bump_changes();
				end else begin
					clear_track(b);
				end
			end
		end
		trk_act[b] = act;
		r.bin_out = b;
		r.action = act;
		r.start_time = trk_start[b];
		r.duration_out = trk_dur[b][15:0];
		r.amplitude_out = trk_amp[b][23:0];
		r.change_count = trk_changes;
		r.frame_last = fend;
		if (fend)
			trk_changes = '0;
		return r;
	endfunction

	// send one bin word, with a random gap ahead of it
	task automatic send_bin(logic [8:0] b, logic pk, logic [23:0] mag, logic [31:0] t,
			logic fend);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.bin <= b;
		item.is_peak <= pk;
		item.magnitude <= mag;
		item.frame_time <= t;
		item.frame_end <= fend;
		do @(posedge clk); while (!item.ready);
		pending_tracks.push_back(track_bin(b, pk, mag, t, fend));
		words_sent++;
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic drain();
		item.valid <= 1'b0;
		while (pending_tracks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; the caller drops the write enable afterwards
	task automatic write_reg(logic idx, logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		if (idx == REG_MIN_LEN)
			trk_min_len = val;
		else
			trk_prox = val;
	endtask

	task automatic configure(logic [15:0] min_len, logic [15:0] prox);
		write_reg(REG_MIN_LEN, min_len);
		write_reg(REG_GAP_LIMIT, prox);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// an event at the top bin across a time wrap, and a short record dropped at bin 0
	task automatic test_event_lifecycle();
		logic [31:0] t;
		configure(16'd3, 16'd2);
		t = 32'hFFFF_FFFE;
		send_bin(9'd511, 1'b1, 24'hFFFFFF, t, 1'b1); t++;
		send_bin(9'd511, 1'b1, 24'h000000, t, 1'b1); t++;
		send_bin(9'd511, 1'b0, 24'h123456, t, 1'b1); t++;
		send_bin(9'd511, 1'b1, 24'hFFFFFF, t, 1'b1); t++;
		repeat (3) begin
			send_bin(9'd511, 1'b0, 24'h0, t, 1'b1); t++;
		end
		send_bin(9'd511, 1'b1, 24'hABCDEF, t, 1'b1); t++;
		send_bin(9'd0, 1'b0, 24'h0, 32'h0, 1'b0);
		send_bin(9'd0, 1'b1, 24'h800000, 32'h0, 1'b0);
		repeat (3)
			send_bin(9'd0, 1'b0, 24'h0, 32'h1, 1'b0);
		send_bin(9'd0, 1'b1, 24'h000001, 32'h5, 1'b1);
		drain();
	endtask

	// zero minimum duration: nothing starts, yet long gaps still report finished
	task automatic test_zero_min_len();
		configure(16'd0, 16'd0);
		send_bin(9'd170, 1'b1, 24'h00FF00, 32'd7, 1'b0);
		send_bin(9'd170, 1'b0, 24'h0, 32'd8, 1'b1);
		send_bin(9'd170, 1'b1, 24'h0000FF, 32'd9, 1'b1);
		send_bin(9'd341, 1'b1, 24'hFFFFFF, 32'd9, 1'b1);
		drain();
		configure(16'hFFFF, 16'hFFFF);
		send_bin(9'd341, 1'b1, 24'h0, 32'd10, 1'b1);
		send_bin(9'd341, 1'b0, 24'h0, 32'd11, 1'b1);
		drain();
	endtask

	// alternate starts and finishes on one bin so the frame count climbs high
	task automatic test_many_changes();
		configure(16'd1, 16'd0);
		for (int i = 0; i < 160; i++)
			send_bin(9'd77, ~i[0], 24'(i), 32'd100, 1'b0);
		send_bin(9'd77, 1'b1, 24'h1, 32'd100, 1'b1);
		send_bin(9'd77, 1'b0, 24'h1, 32'd101, 1'b1);
		drain();
	endtask

	// a long bridged gap is counted into the duration in one step
	task automatic test_long_gap();
		configure(16'd2, 16'hFFFF);
		send_bin(9'd300, 1'b1, 24'h400000, 32'd0, 1'b1);
		for (int i = 0; i < 120; i++)
			send_bin(9'd300, 1'b0, 24'h0, 32'(i + 1), 1'b1);
		send_bin(9'd300, 1'b1, 24'hFFFFFF, 32'd121, 1'b1);
		send_bin(9'd300, 1'b1, 24'h000000, 32'd122, 1'b1);
		drain();
	endtask

	// receiver holds off at length while words keep coming, then the sender waits it out
	task automatic test_backpressure();
		configure(16'd2, 16'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		for (int i = 0; i < 24; i++)
			send_bin(9'(i % 3), i[1], 24'($urandom), 32'(i / 3), (i % 3) == 2);
		drain();
	endtask

	// one stretch of random frames over a small pool of bins, plus noise words
	task automatic random_frames(int words);
		logic [8:0] pool[6];
		logic [31:0] t;
		int n;
		int pk_pct;
		foreach (pool[i])
			pool[i] = 9'($urandom);
		t = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom;
		pk_pct = $urandom_range(35, 85);
		n = 0;
		while (n < words) begin
			foreach (pool[i]) begin
				if ($urandom_range(9) == 0) begin
					send_bin(9'($urandom), 1'($urandom), 24'($urandom), $urandom,
						1'($urandom));
					n++;
				end
				send_bin(pool[i], $urandom_range(99) < pk_pct, 24'($urandom), t,
					i == 5);
				n++;
			end
			t++;
		end
	endtask

	task automatic test_random();
		logic [15:0] mins[5] = '{16'd1, 16'd0, 16'd2, 16'd5, 16'hFFFF};
		logic [15:0] proxs[5] = '{16'd0, 16'd3, 16'd1, 16'd4, 16'd0};
		int sends[4] = '{0, 47, 0, 22};
		int stalls[4] = '{0, 0, 47, 22};
		for (int p = 0; p < 5; p++) begin
			configure(mins[p], proxs[p]);
			for (int m = 0; m < 4; m++) begin
				send_idle_pct = sends[m];
				recv_stall_pct = stalls[m];
				random_frames(16);
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// receiver: random stalls, or a long counted hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left <= 300;
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		track_word_t e;
		if (arst_n && result.valid && result.ready) begin
			if (pending_tracks.size() == 0) begin
				$error("result word with nothing expected, bin %0d", result.bin_out);
				fail_count++;
			end else begin
				e = pending_tracks.pop_front();
				words_checked++;
				if (e.action == ACT_START) starts_seen++;
				if (e.action == ACT_FINISH) finishes_seen++;
				if (result.bin_out !== e.bin_out) begin
					$error("bin_out: expected %0d, got %0d", e.bin_out, result.bin_out);
					fail_count++;
				end
				if (result.action !== e.action) begin
					$error("action: expected %0d, got %0d", e.action, result.action);
					fail_count++;
				end
				if (result.start_time !== e.start_time) begin
					$error("start_time: expected %h, got %h", e.start_time,
						result.start_time);
					fail_count++;
				end
				if (result.duration_out !== e.duration_out) begin
					$error("duration_out: expected %0d, got %0d", e.duration_out,
						result.duration_out);
					fail_count++;
				end
				if (result.amplitude_out !== e.amplitude_out) begin
					$error("amplitude_out: expected %h, got %h", e.amplitude_out,
						result.amplitude_out);
					fail_count++;
				end
				if (result.change_count !== e.change_count) begin
					$error("change_count: expected %0d, got %0d", e.change_count,
						result.change_count);
					fail_count++;
				end
				if (result.frame_last !== e.frame_last) begin
					$error("frame_last: expected %0d, got %0d", e.frame_last,
						result.frame_last);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = 1'b0;
		wr_data = '0;
		item.valid = 1'b0;
		item.bin = '0;
		item.is_peak = 1'b0;
		item.magnitude = '0;
		item.frame_time = '0;
		item.frame_end = 1'b0;
		hold_request = 1'b0;
		fail_count = 0;
		words_sent = 0;
		words_checked = 0;
		starts_seen = 0;
		finishes_seen = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int b = 0; b < NBINS; b++) begin
			trk_act[b] = ACT_NONE;
			clear_track(b);
		end
		trk_changes = '0;
		trk_min_len = MIN_LEN_RST;
		trk_prox = GAP_LIMIT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_event_lifecycle();
		test_zero_min_len();
		test_backpressure();
		test_many_changes();
		test_long_gap();
		test_random();
		drain();

		$display("Sent %0d bin words, checked %0d results (%0d starts, %0d finishes),",
			words_sent, words_checked, starts_seen, finishes_seen);
		$display("over register extremes, idle and stall mixes, long gaps and busy frames.");
		if (fail_count == 0 && pending_tracks.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### filelist.f
+incdir+hdl
hdl/sbet_pkg.sv
hdl/sbet_item_if.sv
hdl/sbet_result_if.sv
hdl/sbet_front.sv
hdl/sbet_div.sv
hdl/sbet_back.sv
hdl/spectral_bin_event_tracker.sv
verif/spectral_bin_event_tracker_tb.sv
